[rtl/five_axis_table_interpolator_core_macros.svh]
// assertion macros shared by the interpolator rtl
`ifndef FIVE_AXIS_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`define FIVE_AXIS_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define FAI_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fai assertion failed");
`define FAI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fai assertion failed");
`else
`define FAI_ASSERT_SAME(label, clk, rst, ante, cons)
`define FAI_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/fai_pkg.sv]
// shared types and constants of the five-axis table interpolator
package fai_pkg;
   localparam int AXES = 5;
   localparam int LEVELS = 5;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W = 4;

   localparam logic [1:0] CMD_POINT  = 2'd0;
   localparam logic [1:0] CMD_CELL   = 2'd1;
   localparam logic [1:0] CMD_LOOKUP = 2'd2;

   typedef struct packed {
      logic [1:0]         command;
      logic [2:0]         axis_select;
      logic [2:0]         point_index;
      logic [14:0]        cell_index;
      logic signed [31:0] write_value_a;
      logic signed [31:0] write_value_b;
      logic signed [31:0] query_height;
      logic signed [31:0] query_speed;
      logic signed [31:0] query_mass;
      logic signed [31:0] query_diameter;
      logic signed [31:0] query_length;
   } req_type;

   typedef struct packed {
      logic signed [31:0] flight_time;
      logic signed [31:0] horizontal_distance;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] tval;
      logic signed [31:0] dval;
   } pair_type;

   typedef struct packed {
      logic    valid;
      req_type item;
   } queue_type;
endpackage

[rtl/fai_ram.sv]
// generic single-write, single-read ram with registered read data
module fai_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[rtl/fai_front.sv]
// front end: accepts transactions, drops ones with no effect, two-entry queue
module fai_front #(
   parameter int MAX_AXIS_POINTS = 8,
   parameter int MAX_TABLE_CELLS = 32768
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  fai_pkg::req_type   req_data,
   input  logic               pop,
   output fai_pkg::queue_type queue_out
);
   import fai_pkg::*;

   req_type    entry_ff [2];
   req_type    entry_in [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       keep;
   logic       push;
   logic       take;

   always_comb begin
      unique case (req_data.command)
         CMD_POINT: keep = (32'(req_data.axis_select) < 32'(AXES))
                        && (32'(req_data.point_index) < 32'(MAX_AXIS_POINTS));
         CMD_CELL:   keep = 32'(req_data.cell_index) < 32'(MAX_TABLE_CELLS);
         CMD_LOOKUP: keep = 1'b1;
         default:    keep = 1'b0;
      endcase
   end

   assign req_ready = (count_ff != 2'd2);
   assign push = req_valid && req_ready && keep;
   assign take = pop && (count_ff != 2'd0);

   always_comb begin
      entry_in  = entry_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         entry_in[wr_ptr_ff] = req_data;
         wr_ptr_in = ~wr_ptr_ff;
      end
      if (take) begin
         rd_ptr_in = ~rd_ptr_ff;
      end
      if (push && !take) begin
         count_in = count_ff + 2'd1;
      end else if (take && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign queue_out.valid = (count_ff != 2'd0);
   assign queue_out.item  = entry_ff[rd_ptr_ff];
endmodule

[rtl/fai_back.sv]
// back end: table writes, segment search, fraction divider, corner fetch and blend
module fai_back #(
   parameter int MAX_AXIS_POINTS = 8,
   parameter int MAX_TABLE_CELLS = 32768,
   parameter int FRACTION_BITS   = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  fai_pkg::queue_type       queue_in,
   output logic                     pop,
   input  logic [fai_pkg::AXES-1:0][$clog2(MAX_AXIS_POINTS+1)-1:0] counts,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output fai_pkg::rsp_type         rsp_data
);
   import fai_pkg::*;

   localparam int CNTW = $clog2(MAX_AXIS_POINTS + 1);
   localparam int LOW  = $clog2(MAX_AXIS_POINTS);
   localparam int AAW  = $clog2(AXES * MAX_AXIS_POINTS);
   localparam int TAW  = $clog2(MAX_TABLE_CELLS);
   localparam int IDXW = AXES * CNTW;
   localparam int FRW  = FRACTION_BITS + 1;
   localparam int DIVW = 34;
   localparam int DCW  = $clog2(FRACTION_BITS + 1);
   localparam int PW   = 33 + FRW + 1;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_P0    = 4'd1;
   localparam logic [3:0] S_CHK0  = 4'd2;
   localparam logic [3:0] S_CHKN  = 4'd3;
   localparam logic [3:0] S_SCAN  = 4'd4;
   localparam logic [3:0] S_DIV   = 4'd5;
   localparam logic [3:0] S_PREP  = 4'd6;
   localparam logic [3:0] S_CADDR = 4'd7;
   localparam logic [3:0] S_CDATA = 4'd8;
   localparam logic [3:0] S_MERGE = 4'd9;
   localparam logic [3:0] S_BLEND = 4'd10;
   localparam logic [3:0] S_DONE  = 4'd11;

   function automatic logic [AAW-1:0] point_addr(input logic [2:0] ax,
                                                 input logic [CNTW-1:0] idx);
      point_addr = AAW'(int'(ax) * MAX_AXIS_POINTS + int'(idx));
   endfunction

   function automatic logic [2:0] trailing_ones(input logic [4:0] c);
      logic [2:0] n;
      logic       run;
      n   = 3'd0;
      run = 1'b1;
      for (int b = 0; b < 5; b++) begin
         if (run && c[b]) begin
            n = n + 3'd1;
         end else begin
            run = 1'b0;
         end
      end
      return n;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [33:0] s);
      if (!s[33] && (s[32] || s[31])) begin
         sat32 = 32'sh7fffffff;
      end else if (s[33] && !(s[32] && s[31])) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = s[31:0];
      end
   endfunction

   // state and search registers
   logic [3:0]             state_ff, state_in;
   logic [2:0]             ax_ff, ax_in;
   logic signed [31:0]     query_ff [AXES];
   logic signed [31:0]     query_in [AXES];
   logic signed [31:0]     prev_ff, prev_in;
   logic [CNTW-1:0]        scan_ff, scan_in;
   logic [DIVW-1:0]        rem_ff, rem_in;
   logic [DIVW-1:0]        den_ff, den_in;
   logic [FRW-1:0]         quo_ff, quo_in;
   logic [DCW-1:0]         dcnt_ff, dcnt_in;
   logic [LOW-1:0]         lo_ff [AXES];
   logic [LOW-1:0]         lo_in [AXES];
   logic [FRW-1:0]         frac_ff [AXES];
   logic [FRW-1:0]         frac_in [AXES];
   // corner index registers
   logic [2:0]             step_ff, step_in;
   logic [IDXW-1:0]        sb_ff, sb_in;
   logic [IDXW-1:0]        sacc_ff, sacc_in;
   logic [IDXW-1:0]        base_ff, base_in;
   logic [IDXW-1:0]        cum_ff [AXES];
   logic [IDXW-1:0]        cum_in [AXES];
   logic [4:0]             corner_ff, corner_in;
   logic [IDXW-1:0]        cidx_ff, cidx_in;
   logic                   oor_ff, oor_in;
   // blend registers
   pair_type               val_ff, val_in;
   pair_type               opa_ff, opa_in;
   logic [2:0]             lvl_ff, lvl_in;
   pair_type               hold_ff [LEVELS];
   pair_type               hold_in [LEVELS];
   logic [LEVELS-1:0]      held_ff, held_in;
   logic signed [PW-1:0]   prodt_ff, prodt_in;
   logic signed [PW-1:0]   prodd_ff, prodd_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   // ram ports
   logic                   a_wr_en, a_rd_en;
   logic [AAW-1:0]         a_wr_addr, a_rd_addr;
   logic [31:0]            a_wr_data, a_rd_data;
   logic                   t_wr_en, t_rd_en;
   logic [TAW-1:0]         t_wr_addr, t_rd_addr;
   logic [63:0]            t_wr_data, t_rd_data;

   // scratch
   logic signed [31:0]     pt;
   logic signed [31:0]     qv;
   logic [CNTW-1:0]        cnt_ax;
   logic                   axis_done;
   logic signed [32:0]     num33, den33;
   logic                   ge;
   logic [DIVW-1:0]        diff;
   logic [2:0]             kk;
   logic [2:0]             fsel;
   logic signed [32:0]     dt, dd;
   logic signed [FRW:0]    fs;
   logic signed [PW-1:0]   qt, qd;
   logic signed [33:0]     sumt, sumd;
   req_type                it;

   fai_ram #(.WIDTH(32), .DEPTH(AXES * MAX_AXIS_POINTS)) u_axis_ram (
      .clock   (clock),
      .wr_en   (a_wr_en),
      .wr_addr (a_wr_addr),
      .wr_data (a_wr_data),
      .rd_en   (a_rd_en),
      .rd_addr (a_rd_addr),
      .rd_data (a_rd_data)
   );

   fai_ram #(.WIDTH(64), .DEPTH(MAX_TABLE_CELLS)) u_table_ram (
      .clock   (clock),
      .wr_en   (t_wr_en),
      .wr_addr (t_wr_addr),
      .wr_data (t_wr_data),
      .rd_en   (t_rd_en),
      .rd_addr (t_rd_addr),
      .rd_data (t_rd_data)
   );

   assign it     = queue_in.item;
   assign pt     = a_rd_data;
   assign qv     = query_ff[ax_ff];
   assign cnt_ax = counts[ax_ff];
   assign pop    = queue_in.valid && (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      ax_in        = ax_ff;
      query_in     = query_ff;
      prev_in      = prev_ff;
      scan_in      = scan_ff;
      rem_in       = rem_ff;
      den_in       = den_ff;
      quo_in       = quo_ff;
      dcnt_in      = dcnt_ff;
      lo_in        = lo_ff;
      frac_in      = frac_ff;
      step_in      = step_ff;
      sb_in        = sb_ff;
      sacc_in      = sacc_ff;
      base_in      = base_ff;
      cum_in       = cum_ff;
      corner_in    = corner_ff;
      cidx_in      = cidx_ff;
      oor_in       = oor_ff;
      val_in       = val_ff;
      opa_in       = opa_ff;
      lvl_in       = lvl_ff;
      hold_in      = hold_ff;
      held_in      = held_ff;
      prodt_in     = prodt_ff;
      prodd_in     = prodd_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      a_wr_en   = 1'b0;
      a_wr_addr = point_addr(it.axis_select, CNTW'(it.point_index));
      a_wr_data = it.write_value_a;
      a_rd_en   = 1'b0;
      a_rd_addr = point_addr(ax_ff, '0);
      t_wr_en   = 1'b0;
      t_wr_addr = TAW'(it.cell_index);
      t_wr_data = {it.write_value_a, it.write_value_b};
      t_rd_en   = 1'b0;
      t_rd_addr = TAW'(cidx_ff);

      axis_done = 1'b0;
      num33 = {qv[31], qv} - {prev_ff[31], prev_ff};
      den33 = {pt[31], pt} - {prev_ff[31], prev_ff};
      ge    = rem_ff >= den_ff;
      diff  = ge ? (rem_ff - den_ff) : rem_ff;
      kk    = 3'(AXES - 1) - step_ff;
      fsel  = 3'(AXES - 1) - lvl_ff;
      dt    = '0;
      dd    = '0;
      fs    = $signed({1'b0, frac_ff[fsel]});
      qt    = prodt_ff >>> FRACTION_BITS;
      qd    = prodd_ff >>> FRACTION_BITS;
      sumt  = $signed({{2{opa_ff.tval[31]}}, opa_ff.tval}) + $signed(qt[33:0]);
      sumd  = $signed({{2{opa_ff.dval[31]}}, opa_ff.dval}) + $signed(qd[33:0]);

      unique case (state_ff)
         S_IDLE: begin
            if (queue_in.valid) begin
               unique case (it.command)
                  CMD_POINT: a_wr_en = 1'b1;
                  CMD_CELL:  t_wr_en = 1'b1;
                  CMD_LOOKUP: begin
                     query_in[0] = it.query_height;
                     query_in[1] = it.query_speed;
                     query_in[2] = it.query_mass;
                     query_in[3] = it.query_diameter;
                     query_in[4] = it.query_length;
                     ax_in       = 3'd0;
                     state_in    = S_P0;
                  end
                  default: ;
               endcase
            end
         end
         S_P0: begin
            a_rd_en  = 1'b1;
            state_in = S_CHK0;
         end
         S_CHK0: begin
            prev_in = pt;
            if (qv <= pt) begin
               lo_in[ax_ff]   = '0;
               frac_in[ax_ff] = '0;
               axis_done      = 1'b1;
            end else begin
               a_rd_en   = 1'b1;
               a_rd_addr = point_addr(ax_ff, cnt_ax - CNTW'(1));
               state_in  = S_CHKN;
            end
         end
         S_CHKN: begin
            if (qv >= pt) begin
               lo_in[ax_ff]   = LOW'(cnt_ax - CNTW'(2));
               frac_in[ax_ff] = FRW'(1) << FRACTION_BITS;
               axis_done      = 1'b1;
            end else begin
               scan_in   = CNTW'(1);
               a_rd_en   = 1'b1;
               a_rd_addr = point_addr(ax_ff, CNTW'(1));
               state_in  = S_SCAN;
            end
         end
         S_SCAN: begin
            if ((scan_ff < cnt_ax - CNTW'(1)) && (pt < qv)) begin
               prev_in   = pt;
               scan_in   = scan_ff + CNTW'(1);
               a_rd_en   = 1'b1;
               a_rd_addr = point_addr(ax_ff, scan_ff + CNTW'(1));
            end else begin
               lo_in[ax_ff] = LOW'(scan_ff - CNTW'(1));
               if (den33[32] || (den33 == '0)) begin
                  frac_in[ax_ff] = '0;
                  axis_done      = 1'b1;
               end else begin
                  rem_in   = {1'b0, num33};
                  den_in   = {1'b0, den33};
                  quo_in   = '0;
                  dcnt_in  = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            rem_in  = {diff[DIVW-2:0], 1'b0};
            quo_in  = {quo_ff[FRW-2:0], ge};
            dcnt_in = dcnt_ff + DCW'(1);
            if (dcnt_ff == DCW'(FRACTION_BITS)) begin
               frac_in[ax_ff] = {quo_ff[FRW-2:0], ge};
               axis_done      = 1'b1;
            end
         end
         S_PREP: begin
            // stride of corner bit j and the index step when bit j is the carry target
            cum_in[step_ff] = sb_ff - sacc_ff;
            sacc_in         = sacc_ff + sb_ff;
            base_in         = base_ff + IDXW'(lo_ff[kk]) * sb_ff;
            sb_in           = sb_ff * IDXW'(counts[kk]);
            step_in         = step_ff + 3'd1;
            if (step_ff == 3'(AXES - 1)) begin
               cidx_in   = base_ff + IDXW'(lo_ff[kk]) * sb_ff;
               corner_in = '0;
               held_in   = '0;
               state_in  = S_CADDR;
            end
         end
         S_CADDR: begin
            t_rd_en  = 32'(cidx_ff) < 32'(MAX_TABLE_CELLS);
            oor_in   = !(32'(cidx_ff) < 32'(MAX_TABLE_CELLS));
            state_in = S_CDATA;
         end
         S_CDATA: begin
            val_in   = oor_ff ? '0 : pair_type'(t_rd_data);
            lvl_in   = '0;
            state_in = S_MERGE;
         end
         S_MERGE: begin
            if (lvl_ff == 3'(LEVELS)) begin
               state_in = S_DONE;
            end else if (held_ff[lvl_ff]) begin
               opa_in   = hold_ff[lvl_ff];
               dt       = {val_ff.tval[31], val_ff.tval}
                        - {hold_ff[lvl_ff].tval[31], hold_ff[lvl_ff].tval};
               dd       = {val_ff.dval[31], val_ff.dval}
                        - {hold_ff[lvl_ff].dval[31], hold_ff[lvl_ff].dval};
               prodt_in = dt * fs;
               prodd_in = dd * fs;
               state_in = S_BLEND;
            end else begin
               hold_in[lvl_ff] = val_ff;
               held_in[lvl_ff] = 1'b1;
               corner_in       = corner_ff + 5'd1;
               cidx_in         = cidx_ff + cum_ff[trailing_ones(corner_ff)];
               state_in        = S_CADDR;
            end
         end
         S_BLEND: begin
            val_in.tval     = sat32(sumt);
            val_in.dval     = sat32(sumd);
            held_in[lvl_ff] = 1'b0;
            lvl_in          = lvl_ff + 3'd1;
            state_in        = S_MERGE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in.flight_time         = val_ff.tval;
               rsp_in.horizontal_distance = val_ff.dval;
               rsp_valid_in               = 1'b1;
               state_in                   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      if (axis_done) begin
         if (ax_ff == 3'(AXES - 1)) begin
            step_in  = '0;
            sb_in    = IDXW'(1);
            sacc_in  = '0;
            base_in  = '0;
            state_in = S_PREP;
         end else begin
            ax_in    = ax_ff + 3'd1;
            state_in = S_P0;
         end
      end
   end

   always_ff @(posedge clock) begin
      ax_ff     <= ax_in;
      query_ff  <= query_in;
      prev_ff   <= prev_in;
      scan_ff   <= scan_in;
      rem_ff    <= rem_in;
      den_ff    <= den_in;
      quo_ff    <= quo_in;
      dcnt_ff   <= dcnt_in;
      lo_ff     <= lo_in;
      frac_ff   <= frac_in;
      step_ff   <= step_in;
      sb_ff     <= sb_in;
      sacc_ff   <= sacc_in;
      base_ff   <= base_in;
      cum_ff    <= cum_in;
      corner_ff <= corner_in;
      cidx_ff   <= cidx_in;
      oor_ff    <= oor_in;
      val_ff    <= val_in;
      opa_ff    <= opa_in;
      lvl_ff    <= lvl_in;
      hold_ff   <= hold_in;
      prodt_ff  <= prodt_in;
      prodd_ff  <= prodd_in;
      rsp_ff    <= rsp_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
endmodule

[rtl/five_axis_table_interpolator_core.sv]
// top level of the five-axis table interpolator
//
//  channel  direction  handshake              carries
//  req      in         req_valid/req_ready    point write, cell write or lookup
//  rsp      out        rsp_valid/rsp_ready    flight time and horizontal distance
//  csr      in         csr_valid/csr_ready    point count of one axis
//
// writes are done in the back end while it is idle; a lookup's run time is set by
// the bit-serial fraction divider, the axis point scan and the single table port,
// which is read once per corner. reset is synchronous and clears control state
// only; the stores stay undefined until written. a two-entry queue lets requests
// arrive while a lookup runs, and a finished result waits in its own register.
`include "five_axis_table_interpolator_core_macros.svh"
module five_axis_table_interpolator_core #(
   parameter int MAX_AXIS_POINTS = 8,
   parameter int MAX_TABLE_CELLS = 32768,
   parameter int FRACTION_BITS   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  fai_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output fai_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [fai_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fai_pkg::CSR_DATA_W-1:0]      csr_data
);
   import fai_pkg::*;

   localparam int CNTW = $clog2(MAX_AXIS_POINTS + 1);
   localparam logic [CNTW-1:0] CNT_RESET =
      CNTW'((MAX_AXIS_POINTS < 8) ? MAX_AXIS_POINTS : 8);

   logic [AXES-1:0][CNTW-1:0] count_ff, count_in;
   logic [CNTW-1:0]           clamped;
   logic                      counts_ok;
   queue_type                 queue_q;
   logic                      back_pop;

   assign csr_ready = 1'b1;

   always_comb begin
      if (csr_data < CSR_DATA_W'(2)) begin
         clamped = CNTW'(2);
      end else if (32'(csr_data) > 32'(MAX_AXIS_POINTS)) begin
         clamped = CNTW'(MAX_AXIS_POINTS);
      end else begin
         clamped = CNTW'(csr_data);
      end
      count_in = count_ff;
      if (csr_valid && csr_ready && (32'(csr_index) < 32'(AXES))) begin
         count_in[csr_index] = clamped;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= {AXES{CNT_RESET}};
      end else begin
         count_ff <= count_in;
      end
   end

   fai_front #(
      .MAX_AXIS_POINTS (MAX_AXIS_POINTS),
      .MAX_TABLE_CELLS (MAX_TABLE_CELLS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .pop       (back_pop),
      .queue_out (queue_q)
   );

   fai_back #(
      .MAX_AXIS_POINTS (MAX_AXIS_POINTS),
      .MAX_TABLE_CELLS (MAX_TABLE_CELLS),
      .FRACTION_BITS   (FRACTION_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .queue_in  (queue_q),
      .pop       (back_pop),
      .counts    (count_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always_comb begin
      counts_ok = 1'b1;
      for (int k = 0; k < AXES; k++) begin
         if ((count_ff[k] < CNTW'(2)) || (32'(count_ff[k]) > 32'(MAX_AXIS_POINTS))) begin
            counts_ok = 1'b0;
         end
      end
   end

   `FAI_ASSERT_SAME(a_pop_has_item, clock, reset, back_pop, queue_q.valid)
   `FAI_ASSERT_SAME(a_full_has_item, clock, reset, !req_ready, queue_q.valid)
   `FAI_ASSERT_SAME(a_counts_in_range, clock, reset, 1'b1, counts_ok)
   `FAI_ASSERT_NEXT(a_lookup_busy, clock, reset, back_pop && (queue_q.item.command == CMD_LOOKUP), !back_pop)
endmodule

[sim/five_axis_table_interpolator_core_tb.sv]
// self-checking testbench of the five-axis table interpolator core
module five_axis_table_interpolator_core_tb;
   import fai_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int NCELLS = 32768;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   five_axis_table_interpolator_core i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // predictor state
   int axis_val[AXES][8];
   int cell_time[NCELLS];
   int cell_dist[NCELLS];
   int axis_count[AXES] = '{8, 8, 8, 8, 8};
   rsp_type expected_q[$];

   // stimulus side
   req_type pending_q[$];
   int plan_pts[AXES][8];
   int plan_count[AXES];
   int cells_loaded = 0;
   bit quiet = 1'b0;
   int gap_left = 0;
   int stall_left = 0;
   int errors = 0;
   int lookups_checked = 0;
   int writes_done = 0;
   int csr_writes = 0;

   function automatic longint blend(longint a, longint b, longint t);
      longint p;
      p = a + (((b - a) * t) >>> FRAC);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      return p;
   endfunction

   function automatic void locate(int ax, longint q, output int lo, output longint fr);
      int n;
      int i;
      longint num;
      longint den;
      n = axis_count[ax];
      lo = 0;
      fr = 0;
      if (q <= axis_val[ax][0]) return;
      if (q >= axis_val[ax][n-1]) begin
         lo = n - 2;
         fr = longint'(1) << FRAC;
         return;
      end
      i = 1;
      while (i < n - 1 && axis_val[ax][i] < q) i++;
      lo = i - 1;
      num = q - axis_val[ax][i-1];
      den = longint'(axis_val[ax][i]) - axis_val[ax][i-1];
      if (den > 0) fr = (num << FRAC) / den;
   endfunction

   function automatic rsp_type interpolate(req_type r);
      longint q[AXES];
      int lo[AXES];
      longint fr[AXES];
      longint vt[32];
      longint vd[32];
      longint idx;
      int width;
      rsp_type res;
      q[0] = r.query_height;
      q[1] = r.query_speed;
      q[2] = r.query_mass;
      q[3] = r.query_diameter;
      q[4] = r.query_length;
      for (int ax = 0; ax < AXES; ax++) locate(ax, q[ax], lo[ax], fr[ax]);
      // corner bit 4 is the height offset, bit 0 the length offset
      for (int c = 0; c < 32; c++) begin
         idx = 0;
         for (int ax = 0; ax < AXES; ax++)
            idx = idx * axis_count[ax] + lo[ax] + ((c >> (AXES - 1 - ax)) & 1);
         vt[c] = (idx < NCELLS) ? cell_time[idx] : 0;
         vd[c] = (idx < NCELLS) ? cell_dist[idx] : 0;
      end
      width = 32;
      for (int ax = AXES - 1; ax >= 0; ax--) begin
         for (int k = 0; k < width / 2; k++) begin
            vt[k] = blend(vt[2*k], vt[2*k+1], fr[ax]);
            vd[k] = blend(vd[2*k], vd[2*k+1], fr[ax]);
         end
         width = width / 2;
      end
      res.flight_time = vt[0][31:0];
      res.horizontal_distance = vd[0][31:0];
      return res;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_q.size() > 0) begin
            if (!quiet && $urandom_range(0, 9) == 0) begin
               gap_left <= $urandom_range(0, 11);
               req_valid <= 1'b0;
            end else begin
               req_data <= pending_q.pop_front();
               req_valid <= 1'b1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 11);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset && req_valid && req_ready) begin
         case (req_data.command)
            CMD_POINT: begin
               if (req_data.axis_select < AXES)
                  axis_val[req_data.axis_select][req_data.point_index] = req_data.write_value_a;
               writes_done++;
            end
            CMD_CELL: begin
               cell_time[req_data.cell_index] = req_data.write_value_a;
               cell_dist[req_data.cell_index] = req_data.write_value_b;
               writes_done++;
            end
            CMD_LOOKUP: expected_q.push_back(interpolate(req_data));
            default: ;
         endcase
      end
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected result transaction %h", $time, rsp_data);
         end else begin
            exp_rsp = expected_q.pop_front();
            lookups_checked++;
            if (rsp_data.flight_time !== exp_rsp.flight_time) begin
               errors++;
               $display("%0t: flight_time expected %h actual %h", $time,
                        exp_rsp.flight_time, rsp_data.flight_time);
            end
            if (rsp_data.horizontal_distance !== exp_rsp.horizontal_distance) begin
               errors++;
               $display("%0t: horizontal_distance expected %h actual %h", $time,
                        exp_rsp.horizontal_distance, rsp_data.horizontal_distance);
            end
         end
      end
   end

   function automatic req_type random_item();
      req_type r;
      r.command = $urandom;
      r.axis_select = $urandom;
      r.point_index = $urandom;
      r.cell_index = $urandom;
      r.write_value_a = $urandom;
      r.write_value_b = $urandom;
      r.query_height = $urandom;
      r.query_speed = $urandom;
      r.query_mass = $urandom;
      r.query_diameter = $urandom;
      r.query_length = $urandom;
      return r;
   endfunction

   task automatic point_write(int ax, int pt, int value);
      req_type r;
      r = random_item();
      r.command = CMD_POINT;
      r.axis_select = ax;
      r.point_index = pt;
      r.write_value_a = value;
      if (ax < AXES) plan_pts[ax][pt] = value;
      pending_q.push_back(r);
   endtask

   task automatic cell_write(int idx);
      req_type r;
      r = random_item();
      r.command = CMD_CELL;
      r.cell_index = idx;
      pending_q.push_back(r);
   endtask

   task automatic load_axes(bit ascending);
      int v;
      for (int ax = 0; ax < AXES; ax++) begin
         v = int'($urandom_range(0, 4000000)) - 2000000;
         for (int p = 0; p < 8; p++) begin
            point_write(ax, p, ascending ? v : int'($urandom));
            v += $urandom_range(1, 1 << 20);
         end
      end
   endtask

   function automatic int clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fffffff;
      if (v < -64'sd2147483648) return 32'h80000000;
      return int'(v);
   endfunction

   // style: 0 inside a segment, 1 on a point, 2 below, 3 above, 4 extremes
   function automatic int query_value(int ax, int style);
      int n;
      int k;
      longint a;
      longint d;
      n = plan_count[ax];
      case (style)
         0: begin
            k = $urandom_range(0, n - 2);
            a = plan_pts[ax][k];
            d = longint'(plan_pts[ax][k+1]) - a;
            return (d > 0) ? clamp32(a + ($urandom % (d + 1))) : int'(a);
         end
         1: return plan_pts[ax][$urandom_range(0, n - 1)];
         2: return clamp32(longint'(plan_pts[ax][0]) - $urandom_range(0, 100000));
         3: return clamp32(longint'(plan_pts[ax][n-1]) + $urandom_range(0, 100000));
         default: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      endcase
   endfunction

   function automatic int pick_style();
      int s;
      s = $urandom_range(0, 99);
      if (s < 70) return 0;
      if (s < 80) return 1;
      if (s < 89) return 2;
      if (s < 98) return 3;
      return 4;
   endfunction

   task automatic lookup(int style);
      req_type r;
      r = random_item();
      r.command = CMD_LOOKUP;
      r.query_height = query_value(0, style < 0 ? pick_style() : style);
      r.query_speed = query_value(1, style < 0 ? pick_style() : style);
      r.query_mass = query_value(2, style < 0 ? pick_style() : style);
      r.query_diameter = query_value(3, style < 0 ? pick_style() : style);
      r.query_length = query_value(4, style < 0 ? pick_style() : style);
      pending_q.push_back(r);
   endtask

   task automatic csr_write(int idx, int value);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_writes++;
      if (idx < AXES) axis_count[idx] = (value < 2) ? 2 : (value > 8) ? 8 : value;
   endtask

   task automatic configure(int counts[AXES]);
      int v;
      for (int ax = 0; ax < AXES; ax++) begin
         v = counts[ax];
         // out-of-range codes saturate to the same count
         if (v == 8 && $urandom_range(0, 1)) v = $urandom_range(9, 15);
         if (v == 2 && $urandom_range(0, 1)) v = $urandom_range(0, 1);
         csr_write(ax, v);
         plan_count[ax] = counts[ax];
      end
      csr_write($urandom_range(AXES, 7), $urandom);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      do @(posedge clock);
      while (pending_q.size() > 0 || req_valid || expected_q.size() > 0);
      repeat (400) @(posedge clock);
   endtask

   initial begin
      int phases[7][AXES];
      int cells_needed;
      int sel;
      req_type r;
      phases = '{'{8, 2, 2, 2, 2}, '{2, 8, 2, 2, 2}, '{2, 2, 8, 2, 2}, '{2, 2, 2, 8, 2},
                 '{2, 2, 2, 2, 8}, '{3, 3, 3, 3, 3}, '{4, 2, 3, 2, 4}};
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < 7; ph++) begin
         drain();
         configure(phases[ph]);
         load_axes(ph != 2);
         cells_needed = 1;
         for (int ax = 0; ax < AXES; ax++) cells_needed *= phases[ph][ax];
         while (cells_loaded < cells_needed) begin
            cell_write(cells_loaded);
            cells_loaded++;
         end
         if (ph == 0) begin
            for (int s = 0; s < 5; s++) lookup(s);
            lookup(4);
            lookup(1);
            r = random_item();
            r.command = 2'd3;
            pending_q.push_back(r);
            point_write(5, 3, $urandom);
            point_write(7, 7, $urandom);
            r = random_item();
            r.command = CMD_CELL;
            r.cell_index = 15'h7fff;
            r.write_value_a = 32'h80000000;
            r.write_value_b = 32'h7fffffff;
            pending_q.push_back(r);
            point_write(4, 7, 32'h7fffffff);
            point_write(3, 7, 32'h80000000);
            lookup(3);
         end
         if (ph == 6) quiet = 1'b1;
         for (int i = 0; i < 73; i++) begin
            sel = $urandom_range(0, 99);
            if (sel < 66) lookup(-1);
            else if (sel < 72) lookup(4);
            else if (sel < 82) cell_write($urandom_range(0, cells_loaded - 1));
            else if (sel < 85) cell_write($urandom_range(0, NCELLS - 1));
            else if (sel < 89) point_write($urandom_range(0, AXES - 1), $urandom_range(0, 7),
                                           $urandom);
            else if (sel < 95) begin
               r = random_item();
               r.command = 2'd3;
               pending_q.push_back(r);
            end else point_write($urandom_range(AXES, 7), $urandom_range(0, 7), $urandom);
         end
      end
      drain();
      $display("run covered %0d lookup results, %0d store writes, %0d register writes",
               lookups_checked, writes_done, csr_writes);
      $display("seven point-count settings, both extremes on every axis, random idling");
      if (errors == 0 && expected_q.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #20ms;
      $display("timeout with %0d results outstanding", expected_q.size());
      $display("CHECK FAILED");
      $finish;
   end
endmodule
